// File: src/rrts_pkg.sv
// Shared types, sizes and codes for the round-robin time-slice scheduler.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rrts_pkg;

    localparam int ADMIT_DEPTH = 16;
    localparam int RING_DEPTH  = 16;
    localparam int STACK_DEPTH = 16;

    localparam int AIW = $clog2(ADMIT_DEPTH);
    localparam int ACW = $clog2(ADMIT_DEPTH + 1);
    localparam int RCW = $clog2(RING_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    localparam int JOB_ID_W   = 16;
    localparam int JOB_TIME_W = 16;
    localparam int QUANTUM_W  = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int JOB_W      = JOB_ID_W + JOB_TIME_W;
    localparam int DATA_W     = ((JOB_W + 7) / 8) * 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(1);

    typedef logic [JOB_ID_W-1:0]   job_id_t;
    typedef logic [JOB_TIME_W-1:0] job_time_t;
    typedef logic [QUANTUM_W-1:0]  quantum_t;

    typedef struct packed {
        job_time_t job_time;
        job_id_t   job_id;
    } job_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_UNLOAD = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN      = 3'd0,
        ST_IDLE     = 3'd1,
        ST_UNLOADED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_REFUSED  = 3'd4
    } status_t;

    typedef struct packed {
        logic full;
        logic empty;
        job_t head;
    } fifo_stat_t;

    typedef struct packed {
        logic    full;
        logic    empty;
        job_id_t top;
    } stack_stat_t;

    typedef struct packed {
        logic    admit_take;
        logic    finish_push;
        job_id_t finish_id;
    } ring_ctl_t;

    typedef struct packed {
        logic      run;
        job_id_t   job_id;
        job_time_t remaining;
    } tick_res_t;

endpackage

`default_nettype wire

// File: src/rrts_admit_fifo.sv
// Admission FIFO of jobs waiting to enter the ring, as a circular register array.
// Depends on rrts_pkg.
`default_nettype none

module rrts_admit_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rrts_pkg::job_t     push_job,
    input  logic               pop,
    output rrts_pkg::fifo_stat_t stat
);
    import rrts_pkg::*;

    job_t           mem_reg [ADMIT_DEPTH];
    logic [AIW-1:0] head_reg;
    logic [AIW-1:0] head_next;
    logic [ACW-1:0] count_reg;
    logic [ACW-1:0] count_next;
    logic [ACW:0]   tail_sum;
    logic [ACW:0]   tail_wrap;
    logic [AIW-1:0] tail;
    logic           full;
    logic           empty;
    logic           push_ok;
    logic           pop_ok;

    assign full    = (count_reg == ACW'(ADMIT_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        tail_sum  = (ACW+1)'(head_reg) + (ACW+1)'(count_reg);
        tail_wrap = (tail_sum >= (ACW+1)'(ADMIT_DEPTH)) ?
                    tail_sum - (ACW+1)'(ADMIT_DEPTH) : tail_sum;
        tail      = tail_wrap[AIW-1:0];
        head_next = head_reg;
        if (pop_ok)
        begin
            head_next = (head_reg == AIW'(ADMIT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        count_next = count_reg + ACW'(push_ok) - ACW'(pop_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[tail] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign stat.full  = full;
    assign stat.empty = empty;
    assign stat.head  = mem_reg[head_reg];

endmodule

`default_nettype wire

// File: src/rrts_done_stack.sv
// Completion stack holding the ids of finished jobs until they are unloaded.
// Depends on rrts_pkg.
`default_nettype none

module rrts_done_stack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rrts_pkg::job_id_t     push_id,
    input  logic                  pop,
    output rrts_pkg::stack_stat_t stat
);
    import rrts_pkg::*;

    job_id_t        mem_reg [STACK_DEPTH];
    logic [SCW-1:0] count_reg;
    logic [SCW-1:0] count_next;
    logic [SCW-1:0] top_cnt;
    logic [SIW-1:0] top_idx;
    logic [SIW-1:0] push_idx;
    logic           full;
    logic           empty;
    logic           push_ok;
    logic           pop_ok;

    assign full     = (count_reg == SCW'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign top_cnt  = count_reg - 1'b1;
    assign top_idx  = top_cnt[SIW-1:0];
    assign push_idx = count_reg[SIW-1:0];

    always_comb
    begin
        count_next = count_reg + SCW'(push_ok) - SCW'(pop_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[push_idx] <= push_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.full  = full;
    assign stat.empty = empty;
    assign stat.top   = mem_reg[top_idx];

endmodule

`default_nettype wire

// File: src/rrts_ring.sv
// Run ring as a shift line with its head always in slot 0, plus the tick datapath:
// retire a finished head, admit one job, run one slice and rotate. Depends on rrts_pkg.
`default_nettype none

module rrts_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  rrts_pkg::quantum_t  quantum,
    input  logic                admit_valid,
    input  rrts_pkg::job_t      admit_job,
    input  logic                stack_full,
    output rrts_pkg::ring_ctl_t ctl,
    output rrts_pkg::tick_res_t res
);
    import rrts_pkg::*;

    job_t           slot_reg  [RING_DEPTH];
    job_t           slot_next [RING_DEPTH];
    job_t           ext       [RING_DEPTH + 2];
    logic [RCW-1:0] count_reg;
    logic [RCW-1:0] count_next;
    logic [RCW-1:0] n1;
    logic [RCW-1:0] n2;
    logic [RCW-1:0] a_pos;
    logic [RCW-1:0] h_pos;
    logic [1:0]     shift;
    logic           retire;
    logic           admit;
    logic           run;
    logic           rotate;
    job_t           head;
    job_time_t      rem;

    always_comb
    begin
        // A finished head leaves for the stack only when the stack has room.
        retire = (count_reg != '0) && (slot_reg[0].job_time == '0) && !stack_full;
        n1     = count_reg - RCW'(retire);
        admit  = admit_valid && (n1 != RCW'(RING_DEPTH));
        n2     = n1 + RCW'(admit);
        run    = (n2 != '0);

        if (n1 == '0)
        begin
            head = admit_job;
        end
        else if (retire)
        begin
            head = slot_reg[1];
        end
        else
        begin
            head = slot_reg[0];
        end

        rem    = (head.job_time > quantum) ? head.job_time - quantum : '0;
        rotate = run && (rem != '0);
        shift  = {1'b0, retire} + {1'b0, rotate};
        a_pos  = n1 - RCW'(rotate);
        h_pos  = rotate ? n2 - 1'b1 : '0;

        for (int i = 0; i < RING_DEPTH + 2; i++)
        begin
            ext[i] = slot_reg[(i < RING_DEPTH) ? i : RING_DEPTH - 1];
        end

        for (int i = 0; i < RING_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (tick)
            begin
                slot_next[i] = ext[i + int'(shift)];
                if (admit && (a_pos == RCW'(i)))
                begin
                    slot_next[i] = admit_job;
                end
                if (run && (h_pos == RCW'(i)))
                begin
                    slot_next[i].job_id   = head.job_id;
                    slot_next[i].job_time = rem;
                end
            end
        end

        count_next = tick ? n2 : count_reg;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign ctl.admit_take  = tick && admit;
    assign ctl.finish_push = tick && retire;
    assign ctl.finish_id   = slot_reg[0].job_id;
    assign res.run         = run;
    assign res.job_id      = head.job_id;
    assign res.remaining   = rem;

endmodule

`default_nettype wire

// File: src/round_robin_time_slice_scheduler_core.sv
// Top level of the round-robin time-slice scheduler: input register, command decode,
// result register and quantum register. Depends on rrts_pkg and the three submodules.
//
// Each beat carries one command (load, tick or unload) in s_axis_tuser and a job in
// s_axis_tdata. A beat is registered, then executed against the admission FIFO, the
// run ring and the completion stack, and its result, if any, is registered for m_axis.
// One beat is taken every cycle as long as m_axis_tready stays high; a result passes
// through the input register and the result register before it is presented on m_axis.
// A successful load and command code three give no result. The quantum is written
// through cfg_wr_en and cfg_wr_data and resets to one; the user must write it only
// while the block is idle, which the block itself does not enforce.
`default_nettype none

module round_robin_time_slice_scheduler_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // job_id [15:0], job_time [31:16]
    input  logic [rrts_pkg::DATA_W-1:0]   s_axis_tdata,
    // command [1:0]
    input  logic [rrts_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_job_id [15:0], out_remaining [31:16]
    output logic [rrts_pkg::DATA_W-1:0]   m_axis_tdata,
    // status [2:0]
    output logic [rrts_pkg::STATUS_W-1:0] m_axis_tuser,
    input  logic                          cfg_wr_en,
    input  logic [rrts_pkg::QUANTUM_W-1:0] cfg_wr_data
);
    import rrts_pkg::*;

    logic             in_valid_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    job_t             in_job_reg;
    quantum_t         quantum_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    job_id_t          out_id_reg;
    job_time_t        out_rem_reg;

    logic             proceed;
    logic             has_res;
    status_t          res_status;
    job_id_t          res_id;
    job_time_t        res_rem;
    logic             fifo_push;
    logic             stack_pop;
    logic             tick;

    fifo_stat_t       fifo_stat;
    stack_stat_t      stack_stat;
    ring_ctl_t        ring_ctl;
    tick_res_t        tick_res;

    assign proceed       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proceed;

    always_comb
    begin
        has_res    = 1'b0;
        res_status = ST_RUN;
        res_id     = '0;
        res_rem    = '0;
        fifo_push  = 1'b0;
        stack_pop  = 1'b0;
        tick       = 1'b0;
        case (cmd_t'(in_cmd_reg))
            CMD_LOAD:
            begin
                if (fifo_stat.full)
                begin
                    has_res    = proceed;
                    res_status = ST_REFUSED;
                end
                else
                begin
                    fifo_push = proceed;
                end
            end
            CMD_TICK:
            begin
                tick    = proceed;
                has_res = proceed;
                if (tick_res.run)
                begin
                    res_status = ST_RUN;
                    res_id     = tick_res.job_id;
                    res_rem    = tick_res.remaining;
                end
                else
                begin
                    res_status = ST_IDLE;
                end
            end
            CMD_UNLOAD:
            begin
                has_res = proceed;
                if (stack_stat.empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    stack_pop  = proceed;
                    res_status = ST_UNLOADED;
                    res_id     = stack_stat.top;
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase

        if (has_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    rrts_admit_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_job (in_job_reg),
        .pop      (ring_ctl.admit_take),
        .stat     (fifo_stat)
    );

    rrts_done_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (ring_ctl.finish_push),
        .push_id (ring_ctl.finish_id),
        .pop     (stack_pop),
        .stat    (stack_stat)
    );

    rrts_ring u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .quantum     (quantum_reg),
        .admit_valid (!fifo_stat.empty),
        .admit_job   (fifo_stat.head),
        .stack_full  (stack_stat.full),
        .ctl         (ring_ctl),
        .res         (tick_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            quantum_reg   <= QUANTUM_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg <= s_axis_tuser;
            in_job_reg <= job_t'(s_axis_tdata[JOB_W-1:0]);
        end
        if (has_res)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_rem_reg    <= res_rem;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'({out_rem_reg, out_id_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

// File: src/rrts_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top level.
// Depends on rrts_pkg and round_robin_time_slice_scheduler_core.
`default_nettype none

module rrts_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [rrts_pkg::DATA_W-1:0]   m_axis_tdata,
    input wire logic [rrts_pkg::STATUS_W-1:0] m_axis_tuser
);
    import rrts_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result beat dropped while stalled.");

    a_beat_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result beat changed while stalled.");

    a_no_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_IDLE || m_axis_tuser == ST_EMPTY ||
                          m_axis_tuser == ST_REFUSED) |-> m_axis_tdata == '0)
        else $error("Status without a job carries nonzero data.");

    a_unload_no_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_UNLOADED |->
            m_axis_tdata[DATA_W-1:JOB_ID_W] == '0)
        else $error("Unloaded beat carries a remaining time.");

endmodule

bind round_robin_time_slice_scheduler_core rrts_checker u_rrts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
